/* rtl/i2crm_pkg.sv */
package i2crm_pkg;

	localparam int MAX_BURST_DEF = 16;

	typedef enum logic [4:0] {
		ST_IDLE, ST_PSTOP_A, ST_PSTOP_B, ST_PSTOP_C, ST_START_A, ST_START_B,
		ST_TX_LO, ST_TX_HI, ST_ACK_WAIT, ST_ACK_HI, ST_RX_LO, ST_RX_HI,
		ST_MACK_LO, ST_MACK_HI, ST_STOP_A, ST_STOP_B, ST_STOP_C
	} seq_t;

	typedef enum logic [2:0] {
		OPC_TICK = 3'd0, OPC_LOAD = 3'd1, OPC_PROBE = 3'd2, OPC_READ = 3'd3,
		OPC_WRITE = 3'd4
	} opc_t;

	typedef enum logic [1:0] {
		AOP_NONE = 2'd0, AOP_PROBE = 2'd1, AOP_READ = 2'd2, AOP_WRITE = 2'd3
	} aop_t;

	typedef enum logic [1:0] {
		STG_ADDR_W = 2'd0, STG_REG = 2'd1, STG_ADDR_R = 2'd2, STG_DATA = 2'd3
	} stg_t;

	localparam logic [1:0] STAT_OK = 2'd0;
	localparam logic [1:0] STAT_NACK = 2'd1;
	localparam logic [1:0] STAT_POLL = 2'd2;

	localparam logic [1:0] REG_DEV = 2'd0;
	localparam logic [1:0] REG_PHASE = 2'd1;
	localparam logic [1:0] REG_ACKW = 2'd2;
	localparam logic [1:0] REG_POLL = 2'd3;

	typedef struct packed {
		logic       scl;
		logic       pull;
		logic       busy;
		logic       rvalid;
		logic [7:0] rbyte;
		logic [3:0] ridx;
		logic       done;
		logic [1:0] status;
		logic       rej;
	} res_t;

endpackage

/* rtl/i2c_register_master_top.sv */
// I2C register master. Each accepted input word is one bus tick: it carries the sampled
// SDA level and optionally a command (load buffer byte, probe, burst read, burst write).
// Exactly one result word is produced per input word, in the next cycle, through an output
// register; an input word can be accepted in every cycle while the output register is
// empty or being drained, so the sustained rate is one tick per clock. Bus phase lengths
// come from the REG_PHASE register, counted in input words, not clocks.
module i2c_register_master_top
	import i2crm_pkg::*;
#(
	parameter int MAX_BURST = MAX_BURST_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	// opcode[2:0], reg_addr[10:3], byte_count[15:11], buf_index[19:16],
	// write_byte[27:20], sda_level[28], zero fill [31:29]
	input  logic [31:0] s_axis_tdata,
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	// scl_level[0], sda_pull_low[1], busy_res[2], read_valid[3], read_byte[11:4],
	// read_index[15:12], done_res[16], status[18:17], cmd_rejected[19], zero [23:20]
	output logic [23:0] m_axis_tdata,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [1:0]  cfg_index,
	input  logic [9:0]  cfg_data
);

	localparam int CW = $clog2(MAX_BURST + 1);

	logic [2:0] opcode;
	logic [7:0] reg_addr;
	logic [4:0] byte_count;
	logic [3:0] buf_index;
	logic [7:0] write_byte;
	logic       sda;
	assign opcode     = s_axis_tdata[2:0];
	assign reg_addr   = s_axis_tdata[10:3];
	assign byte_count = s_axis_tdata[15:11];
	assign buf_index  = s_axis_tdata[19:16];
	assign write_byte = s_axis_tdata[27:20];
	assign sda        = s_axis_tdata[28];

	logic [6:0] dev_q;
	logic [7:0] phase_q, ackl_q;
	logic [9:0] polll_q;

	seq_t       st_q, st_d;
	logic [7:0] tick_q, tick_d;
	logic [3:0] bit_q, bit_d;
	logic [4:0] pos_q, pos_d;
	logic [7:0] sh_q, sh_d;
	logic [7:0] ackc_q, ackc_d;
	logic [9:0] pollc_q, pollc_d;
	aop_t       aop_q, aop_d;
	logic [7:0] lreg_q, lreg_d;
	logic [CW-1:0] lcnt_q, lcnt_d;
	logic [1:0] rst_q, rst_d;
	stg_t       stg_q, stg_d;

	res_t res, res_s1;
	logic out_v_q;
	logic acc;

	assign s_axis_tready = !out_v_q || m_axis_tready;
	assign acc = s_axis_tvalid && s_axis_tready;
	assign cfg_ready = 1'b1;
	assign m_axis_tvalid = out_v_q;
	assign m_axis_tdata = {4'd0, res_s1.rej, res_s1.status, res_s1.done, res_s1.ridx,
		res_s1.rbyte, res_s1.rvalid, res_s1.busy, res_s1.pull, res_s1.scl};

	logic       wb_we;
	logic [3:0] wb_ra;
	logic [7:0] wb_rd;
	assign wb_we = acc && st_q == ST_IDLE && opcode == OPC_LOAD;

	// The next data byte's slot is fixed by the stage and position from the ack wait on,
	// so the registered read is settled before the acknowledged byte is followed.
	assign wb_ra = (stg_q == STG_REG) ? 4'd0 : (pos_q[3:0] + 4'd1);

	i2crm_wbuf #(
		.WIDTH(8), .DEPTH(16)
	) u_wbuf (
		.clk(clk), .we(wb_we), .waddr(buf_index), .wdata(write_byte),
		.raddr(wb_ra), .rdata(wb_rd)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dev_q   <= 7'd41;
			phase_q <= 8'd2;
			ackl_q  <= 8'd200;
			polll_q <= 10'd1000;
		end else if (cfg_valid) begin
			case (cfg_index)
				REG_DEV:   dev_q   <= cfg_data[6:0];
				REG_PHASE: phase_q <= cfg_data[7:0];
				REG_ACKW:  ackl_q  <= cfg_data[7:0];
				REG_POLL:  polll_q <= cfg_data;
				default:   ;
			endcase
		end
	end

	logic [7:0] ph_lim, ack_lim;
	logic [9:0] poll_lim;
	logic       pend;
	logic       ld_tx;
	stg_t       ld_stg;
	logic [CW-1:0] cnt_in;
	logic [4:0] pos_inc;
	logic [7:0] ackc_inc;
	logic [9:0] pollc_inc;
	logic [3:0] bit_inc;
	logic       more;

	assign ph_lim   = (phase_q == 8'd0) ? 8'd1 : phase_q;
	assign ack_lim  = (ackl_q == 8'd0) ? 8'd1 : ackl_q;
	assign poll_lim = (polll_q == 10'd0) ? 10'd1 : polll_q;
	assign pend     = ({1'b0, tick_q} + 9'd1) >= {1'b0, ph_lim};

	always_comb begin
		if (byte_count == 5'd0) cnt_in = CW'(1);
		else if (32'(byte_count) > MAX_BURST) cnt_in = CW'(MAX_BURST);
		else cnt_in = CW'(byte_count);
	end

	// Bus sequencer next state; transmit loads of the data stage take the buffer byte at the new byte position via sh_n.
	always_comb begin
		seq_t cur;
		st_d = st_q; tick_d = tick_q; bit_d = bit_q; pos_d = pos_q; sh_d = sh_q;
		ackc_d = ackc_q; pollc_d = pollc_q; aop_d = aop_q; lreg_d = lreg_q;
		lcnt_d = lcnt_q; rst_d = rst_q; stg_d = stg_q;
		ld_tx = 1'b0; ld_stg = STG_ADDR_W;
		pos_inc = 5'd0; ackc_inc = 8'd0; pollc_inc = 10'd0; bit_inc = 4'd0; more = 1'b0;
		res = '0;
		res.scl = 1'b1;

		if (acc && (opcode == OPC_LOAD || opcode == OPC_PROBE || opcode == OPC_READ
			|| opcode == OPC_WRITE)) begin
			if (st_q != ST_IDLE) begin
				res.rej = 1'b1;
			end else if (opcode != OPC_LOAD) begin
				lcnt_d = cnt_in; lreg_d = reg_addr; rst_d = STAT_OK; pollc_d = '0;
				pos_d = '0; bit_d = '0; ackc_d = '0; stg_d = STG_ADDR_W;
				aop_d = aop_t'(opcode[1:0] - 2'd1);
				st_d = (opcode == OPC_WRITE) ? ST_PSTOP_A : ST_START_A;
				tick_d = '0;
			end
		end

		cur = st_d;
		res.busy = acc && cur != ST_IDLE;
		if (acc) begin
			if (cur != ST_IDLE && !pend) tick_d = tick_d + 8'd1;
			case (cur)
				ST_IDLE: ;
				ST_PSTOP_A: begin
					res.scl = 1'b0; res.pull = 1'b1;
					if (pend) begin st_d = ST_PSTOP_B; tick_d = '0; end
				end
				ST_PSTOP_B: begin
					res.pull = 1'b1;
					if (pend) begin st_d = ST_PSTOP_C; tick_d = '0; end
				end
				ST_PSTOP_C: begin
					if (pend) begin stg_d = STG_ADDR_W; st_d = ST_START_A; tick_d = '0; end
				end
				ST_START_A: begin
					if (pend) begin st_d = ST_START_B; tick_d = '0; end
				end
				ST_START_B: begin
					res.pull = 1'b1;
					if (pend) begin ld_tx = 1'b1; ld_stg = stg_d; end
				end
				ST_TX_LO: begin
					res.scl = 1'b0; res.pull = !sh_d[7];
					if (pend) begin st_d = ST_TX_HI; tick_d = '0; end
				end
				ST_TX_HI: begin
					res.pull = !sh_d[7];
					if (pend) begin
						sh_d = {sh_d[6:0], 1'b0};
						bit_inc = bit_d + 4'd1;
						bit_d = bit_inc;
						tick_d = '0;
						if (bit_inc >= 4'd8) begin ackc_d = '0; st_d = ST_ACK_WAIT; end
						else st_d = ST_TX_LO;
					end
				end
				ST_ACK_WAIT: begin
					res.scl = 1'b0;
					tick_d = tick_q;
					if (!sda) begin
						st_d = ST_ACK_HI; tick_d = '0;
					end else begin
						ackc_inc = ackc_d + 8'd1;
						ackc_d = ackc_inc;
						if (ackc_inc == 8'd0 || ackc_inc >= ack_lim) begin
							if (aop_d == AOP_WRITE && stg_d == STG_ADDR_W) begin
								pollc_inc = pollc_d + 10'd1;
								pollc_d = pollc_inc;
								tick_d = '0;
								if (pollc_inc >= poll_lim) begin
									rst_d = STAT_POLL; st_d = ST_STOP_A;
								end else st_d = ST_START_A;
							end else begin
								rst_d = STAT_NACK; st_d = ST_STOP_A; tick_d = '0;
							end
						end
					end
				end
				ST_ACK_HI: begin
					if (pend) begin
						tick_d = '0;
						if (aop_d == AOP_PROBE) begin
							rst_d = STAT_OK; st_d = ST_STOP_A;
						end else if (stg_d == STG_ADDR_W) begin
							ld_tx = 1'b1; ld_stg = STG_REG;
						end else if (aop_d == AOP_READ) begin
							if (stg_d == STG_REG) begin
								stg_d = STG_ADDR_R; st_d = ST_START_A;
							end else begin
								pos_d = '0; bit_d = '0; sh_d = '0; st_d = ST_RX_LO;
							end
						end else if (stg_d == STG_REG) begin
							pos_d = '0; ld_tx = 1'b1; ld_stg = STG_DATA;
						end else begin
							pos_inc = pos_d + 5'd1;
							pos_d = pos_inc;
							if (32'(pos_inc) >= 32'(lcnt_d)) begin
								rst_d = STAT_OK; st_d = ST_STOP_A;
							end else begin
								ld_tx = 1'b1; ld_stg = STG_DATA;
							end
						end
					end
				end
				ST_RX_LO: begin
					res.scl = 1'b0;
					if (pend) begin st_d = ST_RX_HI; tick_d = '0; end
				end
				ST_RX_HI: begin
					if (pend) begin
						sh_d = {sh_d[6:0], sda};
						bit_inc = bit_d + 4'd1;
						bit_d = bit_inc;
						tick_d = '0;
						if (bit_inc >= 4'd8) begin
							res.rvalid = 1'b1; res.rbyte = sh_d; res.ridx = pos_d[3:0];
							st_d = ST_MACK_LO;
						end else st_d = ST_RX_LO;
					end
				end
				ST_MACK_LO, ST_MACK_HI: begin
					more = (32'(pos_d) + 32'd1) < 32'(lcnt_d);
					res.scl = (cur == ST_MACK_HI);
					res.pull = more;
					if (pend) begin
						tick_d = '0;
						if (cur == ST_MACK_LO) st_d = ST_MACK_HI;
						else begin
							pos_inc = pos_d + 5'd1;
							pos_d = pos_inc;
							if (32'(pos_inc) >= 32'(lcnt_d)) begin
								rst_d = STAT_OK; st_d = ST_STOP_A;
							end else begin
								bit_d = '0; sh_d = '0; st_d = ST_RX_LO;
							end
						end
					end
				end
				ST_STOP_A: begin
					res.scl = 1'b0; res.pull = 1'b1;
					if (pend) begin st_d = ST_STOP_B; tick_d = '0; end
				end
				ST_STOP_B: begin
					res.pull = 1'b1;
					if (pend) begin st_d = ST_STOP_C; tick_d = '0; end
				end
				ST_STOP_C: begin
					if (pend) begin res.done = 1'b1; st_d = ST_IDLE; tick_d = '0; end
				end
				default: st_d = ST_IDLE;
			endcase
			if (ld_tx) begin
				stg_d = ld_stg; bit_d = '0; st_d = ST_TX_LO; tick_d = '0;
				case (ld_stg)
					STG_ADDR_W: sh_d = {dev_q, 1'b0};
					STG_ADDR_R: sh_d = {dev_q, 1'b1};
					STG_REG:    sh_d = lreg_d;
					default:    sh_d = 8'h00;
				endcase
			end
		end
		res.status = rst_d;
	end

	// Buffer byte joins the data stage load after the position is settled.
	logic [7:0] sh_n;
	assign sh_n = (acc && ld_tx && ld_stg == STG_DATA) ? wb_rd : sh_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= ST_IDLE; tick_q <= '0; bit_q <= '0; pos_q <= '0; sh_q <= '0;
			ackc_q <= '0; pollc_q <= '0; aop_q <= AOP_NONE; lreg_q <= '0;
			lcnt_q <= '0; rst_q <= STAT_OK; stg_q <= STG_ADDR_W; out_v_q <= 1'b0;
		end else begin
			if (acc) begin
				st_q <= st_d; tick_q <= tick_d; bit_q <= bit_d; pos_q <= pos_d;
				sh_q <= sh_n; ackc_q <= ackc_d; pollc_q <= pollc_d; aop_q <= aop_d;
				lreg_q <= lreg_d; lcnt_q <= lcnt_d; rst_q <= rst_d; stg_q <= stg_d;
				out_v_q <= 1'b1;
			end else if (m_axis_tready) begin
				out_v_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (acc) res_s1 <= res;
	end

endmodule

/* rtl/i2crm_wbuf.sv */
module i2crm_wbuf #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

/* rtl/i2crm_checker.sv */
module i2crm_checker
	import i2crm_pkg::*;
(
	input logic        clk,
	input logic        arst_n,
	input logic        s_axis_tready,
	input logic        m_axis_tvalid,
	input logic        m_axis_tready,
	input logic [23:0] m_axis_tdata
);

	a_stall_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
		else $error("result word changed while stalled");

	a_ready_when_empty: assert property (@(posedge clk) disable iff (!arst_n)
		!m_axis_tvalid |-> s_axis_tready)
		else $error("input not ready with empty output");

	a_read_busy: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && m_axis_tdata[3] |-> m_axis_tdata[2])
		else $error("read byte outside a transaction");

	a_done_busy: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && m_axis_tdata[16] |-> m_axis_tdata[2] && m_axis_tdata[0])
		else $error("done without stop phase");

endmodule

bind i2c_register_master_top i2crm_checker u_chk (
	.clk(clk), .arst_n(arst_n),
	.s_axis_tready(s_axis_tready), .m_axis_tvalid(m_axis_tvalid),
	.m_axis_tready(m_axis_tready), .m_axis_tdata(m_axis_tdata)
);

/* tb/tb_i2c_register_master_top.sv */
module tb_i2c_register_master_top;
	import i2crm_pkg::*;

	localparam int STALL_LIMIT = 20000;

	typedef struct {
		logic [2:0] op;
		logic [7:0] reg_a;
		logic [4:0] cnt;
		logic [3:0] slot;
		logic [7:0] wbyte;
		logic       sda;
	} tick_t;

	logic        clk;
	logic        arst_n;
	logic        s_axis_tvalid;
	logic        s_axis_tready;
	logic [31:0] s_axis_tdata;
	logic        m_axis_tvalid;
	logic        m_axis_tready;
	logic [23:0] m_axis_tdata;
	logic        cfg_valid;
	logic        cfg_ready;
	logic [1:0]  cfg_index;
	logic [9:0]  cfg_data;

	i2c_register_master_top dut (
		.clk(clk), .arst_n(arst_n),
		.s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
		.s_axis_tdata(s_axis_tdata),
		.m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
		.m_axis_tdata(m_axis_tdata),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
		.cfg_index(cfg_index), .cfg_data(cfg_data)
	);

	// Bus sequencer mirror.
	logic [6:0] c_dev;
	logic [7:0] c_phase;
	logic [7:0] c_ackw;
	logic [9:0] c_poll;
	seq_t       b_step;
	logic [7:0] b_tick;
	logic [3:0] b_bits;
	logic [4:0] b_pos;
	logic [7:0] b_shift;
	logic [7:0] b_ackw;
	logic [9:0] b_poll;
	aop_t       b_op;
	logic [7:0] b_reg;
	logic [4:0] b_cnt;
	logic [7:0] b_buf [16];
	logic [1:0] b_stat;
	stg_t       b_stage;

	tick_t tick_q [$];
	res_t  bus_exp_q [$];
	int    errors = 0;
	int    quiet_cycles = 0;
	bit    in_took = 0;
	int    burst_left = 1;
	int    gap_left = 0;
	int    rx_cyc = 0;

	function automatic void goto(seq_t s);
		b_step = s;
		b_tick = 0;
	endfunction

	function automatic bit phase_done();
		int p;
		p = (c_phase == 0) ? 1 : int'(c_phase);
		if (int'(b_tick) + 1 >= p)
			return 1;
		b_tick = b_tick + 8'd1;
		return 0;
	endfunction

	function automatic void send_byte(stg_t s);
		b_stage = s;
		case (s)
			STG_ADDR_W: b_shift = {c_dev, 1'b0};
			STG_ADDR_R: b_shift = {c_dev, 1'b1};
			STG_REG:    b_shift = b_reg;
			default:    b_shift = b_buf[b_pos[3:0]];
		endcase
		b_bits = 0;
		goto(ST_TX_LO);
	endfunction

	function automatic void close_bus(logic [1:0] st);
		b_stat = st;
		goto(ST_STOP_A);
	endfunction

	function automatic void on_ack();
		if (b_op == AOP_PROBE) begin
			close_bus(STAT_OK);
		end else if (b_op == AOP_READ) begin
			if (b_stage == STG_ADDR_W) begin
				send_byte(STG_REG);
			end else if (b_stage == STG_REG) begin
				b_stage = STG_ADDR_R;
				goto(ST_START_A);
			end else begin
				b_pos = 0;
				b_bits = 0;
				b_shift = 0;
				goto(ST_RX_LO);
			end
		end else begin
			if (b_stage == STG_ADDR_W) begin
				send_byte(STG_REG);
			end else if (b_stage == STG_REG) begin
				b_pos = 0;
				send_byte(STG_DATA);
			end else begin
				b_pos = b_pos + 5'd1;
				if (b_pos >= b_cnt)
					close_bus(STAT_OK);
				else
					send_byte(STG_DATA);
			end
		end
	endfunction

	function automatic void on_nack();
		int lim;
		if (b_op == AOP_WRITE && b_stage == STG_ADDR_W) begin
			lim = (c_poll == 0) ? 1 : int'(c_poll);
			b_poll = b_poll + 10'd1;
			if (int'(b_poll) >= lim)
				close_bus(STAT_POLL);
			else
				goto(ST_START_A);
		end else begin
			close_bus(STAT_NACK);
		end
	endfunction

	function automatic res_t bus_tick(tick_t t);
		res_t r;
		int lim;
		logic [4:0] n;
		r = '0;
		r.scl = 1;
		if (t.op >= OPC_LOAD && t.op <= OPC_WRITE) begin
			if (b_step != ST_IDLE) begin
				r.rej = 1;
			end else if (t.op == OPC_LOAD) begin
				b_buf[t.slot] = t.wbyte;
			end else begin
				n = t.cnt;
				if (n == 0)
					n = 1;
				if (n > MAX_BURST_DEF)
					n = MAX_BURST_DEF;
				b_cnt = n;
				b_reg = t.reg_a;
				b_stat = STAT_OK;
				b_poll = 0;
				b_pos = 0;
				b_bits = 0;
				b_ackw = 0;
				b_stage = STG_ADDR_W;
				b_op = aop_t'(t.op[1:0] - 2'd1);
				goto(t.op == OPC_WRITE ? ST_PSTOP_A : ST_START_A);
			end
		end
		r.busy = (b_step != ST_IDLE);
		case (b_step)
			ST_PSTOP_A: begin
				r.scl = 0; r.pull = 1;
				if (phase_done()) goto(ST_PSTOP_B);
			end
			ST_PSTOP_B: begin
				r.pull = 1;
				if (phase_done()) goto(ST_PSTOP_C);
			end
			ST_PSTOP_C: begin
				if (phase_done()) begin
					b_stage = STG_ADDR_W;
					goto(ST_START_A);
				end
			end
			ST_START_A: if (phase_done()) goto(ST_START_B);
			ST_START_B: begin
				r.pull = 1;
				if (phase_done()) send_byte(b_stage);
			end
			ST_TX_LO: begin
				r.scl = 0; r.pull = ~b_shift[7];
				if (phase_done()) goto(ST_TX_HI);
			end
			ST_TX_HI: begin
				r.pull = ~b_shift[7];
				if (phase_done()) begin
					b_shift = b_shift << 1;
					b_bits = b_bits + 4'd1;
					if (b_bits >= 8) begin
						b_ackw = 0;
						goto(ST_ACK_WAIT);
					end else begin
						goto(ST_TX_LO);
					end
				end
			end
			ST_ACK_WAIT: begin
				lim = (c_ackw == 0) ? 1 : int'(c_ackw);
				r.scl = 0;
				if (!t.sda) begin
					goto(ST_ACK_HI);
				end else begin
					b_ackw = b_ackw + 8'd1;
					if (b_ackw == 0 || int'(b_ackw) >= lim)
						on_nack();
				end
			end
			ST_ACK_HI: if (phase_done()) on_ack();
			ST_RX_LO: begin
				r.scl = 0;
				if (phase_done()) goto(ST_RX_HI);
			end
			ST_RX_HI: begin
				if (phase_done()) begin
					b_shift = {b_shift[6:0], t.sda};
					b_bits = b_bits + 4'd1;
					if (b_bits >= 8) begin
						r.rvalid = 1;
						r.rbyte = b_shift;
						r.ridx = b_pos[3:0];
						goto(ST_MACK_LO);
					end else begin
						goto(ST_RX_LO);
					end
				end
			end
			ST_MACK_LO: begin
				r.scl = 0; r.pull = (int'(b_pos) + 1 < int'(b_cnt));
				if (phase_done()) goto(ST_MACK_HI);
			end
			ST_MACK_HI: begin
				r.pull = (int'(b_pos) + 1 < int'(b_cnt));
				if (phase_done()) begin
					b_pos = b_pos + 5'd1;
					if (b_pos >= b_cnt) begin
						close_bus(STAT_OK);
					end else begin
						b_bits = 0;
						b_shift = 0;
						goto(ST_RX_LO);
					end
				end
			end
			ST_STOP_A: begin
				r.scl = 0; r.pull = 1;
				if (phase_done()) goto(ST_STOP_B);
			end
			ST_STOP_B: begin
				r.pull = 1;
				if (phase_done()) goto(ST_STOP_C);
			end
			ST_STOP_C: begin
				if (phase_done()) begin
					r.done = 1;
					goto(ST_IDLE);
				end
			end
			default: b_step = ST_IDLE;
		endcase
		r.status = b_stat;
		return r;
	endfunction

	function automatic logic [31:0] pack_tick(tick_t t);
		return {3'b000, t.sda, t.wbyte, t.slot, t.cnt, t.reg_a, t.op};
	endfunction

	function automatic tick_t unpack_tick(logic [31:0] d);
		tick_t t;
		t.op = d[2:0];
		t.reg_a = d[10:3];
		t.cnt = d[15:11];
		t.slot = d[19:16];
		t.wbyte = d[27:20];
		t.sda = d[28];
		return t;
	endfunction

	task automatic report(string field, int got, int want);
		$display("mismatch at %0t: %s got %0d expected %0d", $realtime, field, got, want);
		errors++;
	endtask

	task automatic push_tick(logic [2:0] op, logic [7:0] ra, logic [4:0] cnt,
			logic [3:0] slot, logic [7:0] wb, logic sda);
		tick_t t;
		t.op = op; t.reg_a = ra; t.cnt = cnt; t.slot = slot; t.wbyte = wb; t.sda = sda;
		tick_q.push_back(t);
	endtask

	task automatic idle_ticks(int n, int low_pct);
		repeat (n)
			push_tick(OPC_TICK, $urandom, $urandom, $urandom, $urandom,
				$urandom_range(99) >= low_pct);
	endtask

	// Hold off until every word is back and the sequencer has reached idle.
	task automatic settle();
		forever begin
			while (tick_q.size() != 0 || bus_exp_q.size() != 0 || s_axis_tvalid)
				@(posedge clk);
			if (b_step == ST_IDLE)
				break;
			idle_ticks(32, 100);
		end
		repeat (4) @(posedge clk);
	endtask

	task automatic write_reg(logic [1:0] idx, logic [9:0] val);
		@(negedge clk);
		cfg_valid <= 1;
		cfg_index <= idx;
		cfg_data <= val;
		do @(posedge clk); while (!cfg_ready);
		case (idx)
			REG_DEV:   c_dev = val[6:0];
			REG_PHASE: c_phase = val[7:0];
			REG_ACKW:  c_ackw = val[7:0];
			default:   c_poll = val;
		endcase
		@(negedge clk);
		cfg_valid <= 0;
	endtask

	task automatic random_phase(int n, int low_pct, int max_cnt, int cmd_pct);
		logic [2:0] op;
		logic [4:0] cnt;
		repeat (n) begin
			if ($urandom_range(99) < cmd_pct) begin
				op = $urandom_range(7);
				if ($urandom_range(9) == 0)
					cnt = $urandom;
				else
					cnt = $urandom_range(max_cnt, 1);
				push_tick(op, $urandom, cnt, $urandom, $urandom, $urandom_range(99) >= low_pct);
			end else begin
				idle_ticks(1, low_pct);
			end
		end
	endtask

	initial begin
		clk = 0;
		forever #5 clk = ~clk;
	end

	// Sender: bursts of random length separated by random gaps.
	always @(negedge clk) begin
		if (!arst_n) begin
			s_axis_tvalid <= 0;
			s_axis_tdata <= '0;
		end else if (!(s_axis_tvalid && !in_took)) begin
			if (gap_left > 0) begin
				gap_left <= gap_left - 1;
				s_axis_tvalid <= 0;
			end else if (tick_q.size() != 0) begin
				s_axis_tdata <= pack_tick(tick_q.pop_front());
				s_axis_tvalid <= 1;
				if (burst_left <= 1) begin
					burst_left <= $urandom_range(40, 1);
					gap_left <= ($urandom_range(2) == 0) ? 0 : $urandom_range(6, 1);
				end else begin
					burst_left <= burst_left - 1;
				end
			end else begin
				s_axis_tvalid <= 0;
			end
		end
		in_took = 0;
	end

	// Receiver stall pattern: free running, random, then sparse.
	always @(negedge clk) begin
		rx_cyc <= rx_cyc + 1;
		case ((rx_cyc / 300) % 3)
			0: m_axis_tready <= 1;
			1: m_axis_tready <= ($urandom_range(3) != 0);
			default: m_axis_tready <= (rx_cyc % 5 == 0);
		endcase
	end

	always @(posedge clk) begin
		res_t got;
		res_t want;
		bit   moved;
		got = m_axis_tdata[19:0];
		got.scl = m_axis_tdata[0]; got.pull = m_axis_tdata[1]; got.busy = m_axis_tdata[2];
		got.rvalid = m_axis_tdata[3]; got.rbyte = m_axis_tdata[11:4];
		got.ridx = m_axis_tdata[15:12]; got.done = m_axis_tdata[16];
		got.status = m_axis_tdata[18:17]; got.rej = m_axis_tdata[19];
		moved = 0;
		if (arst_n && m_axis_tvalid && m_axis_tready) begin
			moved = 1;
			if (bus_exp_q.size() == 0) begin
				report("unexpected word", 1, 0);
			end else begin
				want = bus_exp_q.pop_front();
				if (got.scl !== want.scl) report("scl_level", got.scl, want.scl);
				if (got.pull !== want.pull) report("sda_pull_low", got.pull, want.pull);
				if (got.busy !== want.busy) report("busy_res", got.busy, want.busy);
				if (got.rvalid !== want.rvalid) report("read_valid", got.rvalid, want.rvalid);
				if (got.rbyte !== want.rbyte) report("read_byte", got.rbyte, want.rbyte);
				if (got.ridx !== want.ridx) report("read_index", got.ridx, want.ridx);
				if (got.done !== want.done) report("done_res", got.done, want.done);
				if (got.status !== want.status) report("status", got.status, want.status);
				if (got.rej !== want.rej) report("cmd_rejected", got.rej, want.rej);
			end
		end
		if (arst_n && s_axis_tvalid && s_axis_tready) begin
			moved = 1;
			in_took = 1;
			bus_exp_q.push_back(bus_tick(unpack_tick(s_axis_tdata)));
		end
		if (arst_n && cfg_valid && cfg_ready)
			moved = 1;
		quiet_cycles <= moved ? 0 : quiet_cycles + 1;
		if (quiet_cycles >= STALL_LIMIT) begin
			$display("*** FAILED ***");
			$finish;
		end
	end

	initial begin
		arst_n = 0;
		cfg_valid = 0;
		cfg_index = 0;
		cfg_data = 0;
		m_axis_tready = 0;
		c_dev = 41; c_phase = 2; c_ackw = 200; c_poll = 1000;
		b_step = ST_IDLE; b_tick = 0; b_bits = 0; b_pos = 0; b_shift = 0;
		b_ackw = 0; b_poll = 0; b_op = AOP_NONE; b_reg = 0; b_cnt = 0;
		b_stat = STAT_OK; b_stage = STG_ADDR_W;
		repeat (12) @(posedge clk);
		@(negedge clk);
		arst_n = 1;

		// Fill every buffer slot so no write ever sends an unloaded byte.
		for (int i = 0; i < 16; i++)
			push_tick(OPC_LOAD, 0, 0, i, (i == 0) ? 8'h00 : (i == 15) ? 8'hFF : $urandom, 0);
		push_tick(OPC_PROBE, 8'h00, 5'd1, 0, 0, 1);
		push_tick(OPC_READ, 8'hFF, 5'd1, 0, 0, 1);   // rejected, probe still running
		idle_ticks(60, 100);
		push_tick(OPC_READ, 8'hFF, 5'd2, 0, 0, 0);
		idle_ticks(120, 60);
		push_tick(3'd5, 0, 0, 0, 0, 0);
		push_tick(3'd7, 0, 0, 0, 0, 1);
		push_tick(OPC_WRITE, 8'h00, 5'd0, 0, 0, 0);
		idle_ticks(80, 100);
		push_tick(OPC_WRITE, 8'h5A, 5'd31, 0, 0, 0);
		idle_ticks(20, 100);
		push_tick(OPC_LOAD, 0, 0, 4'd3, 8'hA5, 0);    // rejected load
		settle();
		push_tick(OPC_PROBE, 0, 1, 0, 0, 1);
		idle_ticks(300, 0);                            // nack by ack timeout
		settle();

		write_reg(REG_DEV, 0); write_reg(REG_PHASE, 1);
		write_reg(REG_ACKW, 1); write_reg(REG_POLL, 1);
		random_phase(150, 50, 4, 5);
		settle();
		write_reg(REG_DEV, 127); write_reg(REG_ACKW, 255); write_reg(REG_POLL, 1023);
		random_phase(200, 85, 16, 3);
		settle();
		write_reg(REG_DEV, 85); write_reg(REG_PHASE, 3);
		write_reg(REG_ACKW, 6); write_reg(REG_POLL, 3);
		random_phase(150, 40, 4, 5);
		settle();
		write_reg(REG_DEV, 1); write_reg(REG_PHASE, 12);
		write_reg(REG_ACKW, 255); write_reg(REG_POLL, 4);
		push_tick(OPC_PROBE, 8'h3C, 1, 0, 0, 0);
		idle_ticks(30, 90);
		settle();
		write_reg(REG_DEV, 42); write_reg(REG_PHASE, 2);
		write_reg(REG_ACKW, 200); write_reg(REG_POLL, 1000);
		random_phase(150, 80, 8, 4);
		settle();
		write_reg(REG_DEV, 100); write_reg(REG_PHASE, 1);
		write_reg(REG_ACKW, 2); write_reg(REG_POLL, 2);
		random_phase(200, 60, 16, 5);
		settle();
		repeat (10) @(posedge clk);
		if (errors == 0 && bus_exp_q.size() == 0) begin
			$display("*** PASSED ***");
		end else begin
			$display("*** FAILED ***");
		end
		$finish;
	end

endmodule
